@@ sv/bdhrk_pkg.sv @@
// ----------------------------------------------------------------------------
// bdhrk_pkg: shared types and constants for the button poller
// Slot numbers, event codes, register indexes, sequencer states and the
// short-press key map.
// ----------------------------------------------------------------------------
package bdhrk_pkg;

  localparam int SLOTS = 6;

  localparam logic [2:0] SLOT_UP     = 3'd0;
  localparam logic [2:0] SLOT_DOWN   = 3'd1;
  localparam logic [2:0] SLOT_LEFT   = 3'd2;
  localparam logic [2:0] SLOT_RIGHT  = 3'd3;
  localparam logic [2:0] SLOT_CENTER = 3'd4;
  localparam logic [2:0] SLOT_REC    = 3'd5;

  localparam logic [2:0] ACT_PRESS     = 3'd0;
  localparam logic [2:0] ACT_RELEASE   = 3'd1;
  localparam logic [2:0] ACT_PREV_STRM = 3'd2;
  localparam logic [2:0] ACT_NEXT_STRM = 3'd3;
  localparam logic [2:0] ACT_TOGGLE_REC = 3'd4;
  localparam logic [2:0] ACT_OPEN_MENU = 3'd5;

  localparam logic [3:0] KEY_NONE        = 4'd0;
  localparam logic [3:0] KEY_PREV        = 4'd1;
  localparam logic [3:0] KEY_NEXT        = 4'd2;
  localparam logic [3:0] KEY_OK          = 4'd3;
  localparam logic [3:0] KEY_HOME        = 4'd4;
  localparam logic [3:0] KEY_ESC         = 4'd5;
  localparam logic [3:0] KEY_ARROW_UP    = 4'd6;
  localparam logic [3:0] KEY_ARROW_DOWN  = 4'd7;
  localparam logic [3:0] KEY_ARROW_LEFT  = 4'd8;
  localparam logic [3:0] KEY_ARROW_RIGHT = 4'd9;

  localparam logic [1:0] MODE_NAV    = 2'd0;
  localparam logic [1:0] MODE_LIST   = 2'd1;
  localparam logic [1:0] MODE_SLIDER = 2'd2;

  localparam logic [2:0] REG_PRESS_LOW  = 3'd0;
  localparam logic [2:0] REG_ENABLE     = 3'd1;
  localparam logic [2:0] REG_DEBOUNCE   = 3'd2;
  localparam logic [2:0] REG_HOLD_DELAY = 3'd3;
  localparam logic [2:0] REG_REPEAT     = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEB,
    ST_HOLD,
    ST_FIRE,
    ST_REP,
    ST_DRAIN
  } state_t;

  typedef enum logic {
    ALU_ADD,
    ALU_SUB
  } alu_op_t;

  typedef struct packed {
    logic [2:0] button;
    logic [2:0] action;
    logic [3:0] key;
  } event_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] action;
    logic [3:0] key;
  } map_t;

  // Short press or repeat mapping by menu flag and UI mode.
  function automatic map_t map_short(logic [2:0] b, logic menu, logic [1:0] mode);
    map_t m;
    m.hit    = 1'b0;
    m.action = ACT_PRESS;
    m.key    = KEY_NONE;
    if (!menu && b == SLOT_LEFT) begin
      m.hit    = 1'b1;
      m.action = ACT_PREV_STRM;
    end else if (!menu && b == SLOT_RIGHT) begin
      m.hit    = 1'b1;
      m.action = ACT_NEXT_STRM;
    end else if (!menu && b != SLOT_REC) begin
      m.hit = 1'b0;
    end else begin
      unique case (mode)
        MODE_NAV: begin
          m.hit = 1'b1;
          case (b)
            SLOT_UP:                 m.key = KEY_PREV;
            SLOT_DOWN:               m.key = KEY_NEXT;
            SLOT_RIGHT, SLOT_CENTER: m.key = KEY_OK;
            SLOT_LEFT:               m.key = KEY_HOME;
            SLOT_REC:                m.action = ACT_TOGGLE_REC;
            default:                 m.hit = 1'b0;
          endcase
        end
        MODE_LIST: begin
          m.hit = 1'b1;
          case (b)
            SLOT_UP:     m.key = KEY_ARROW_UP;
            SLOT_DOWN:   m.key = KEY_ARROW_DOWN;
            SLOT_CENTER: m.key = KEY_OK;
            default:     m.hit = 1'b0;
          endcase
        end
        MODE_SLIDER: begin
          m.hit = 1'b1;
          case (b)
            SLOT_LEFT:   m.key = KEY_ARROW_LEFT;
            SLOT_RIGHT:  m.key = KEY_ARROW_RIGHT;
            SLOT_CENTER: m.key = KEY_OK;
            default:     m.hit = 1'b0;
          endcase
        end
        default: begin
          m.hit = 1'b1;
          case (b)
            SLOT_UP:     m.key = KEY_ARROW_UP;
            SLOT_DOWN:   m.key = KEY_ARROW_DOWN;
            SLOT_LEFT:   m.key = KEY_ARROW_LEFT;
            SLOT_RIGHT:  m.key = KEY_ARROW_RIGHT;
            SLOT_CENTER: m.key = KEY_OK;
            default:     m.hit = 1'b0;
          endcase
        end
      endcase
    end
    return m;
  endfunction

endpackage

@@ sv/button_debounce_hold_repeat_keymap.sv @@
// ----------------------------------------------------------------------------
// button_debounce_hold_repeat_keymap: six-button debounce, hold and repeat
// Polls six buttons, debounces them, detects long press and auto-repeat
// and maps each event to a key code or an action by menu flag and UI mode.
// ----------------------------------------------------------------------------
// Sequencing: the slot scan visits the slots in turn; a disabled slot only
// passes the debounce state, an enabled slot runs debounce, optional deadline,
// fire test and optional repeat on one shared time adder. Events then enter
// the output register in order, held while the receiver stalls, and the drain
// closes. A new poll is taken only in idle; poll_stall is high otherwise.
// Reset (rst, synchronous) clears all slot state, the registers to their
// defaults, the sequencer and the output channel.
module button_debounce_hold_repeat_keymap #(
  parameter int TIME_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        poll_valid,
  output logic        poll_stall,
  input  logic [31:0] now_ms,
  input  logic [5:0]  levels,
  input  logic        menu_open,
  input  logic [1:0]  ui_mode,
  output logic        event_valid,
  input  logic        event_stall,
  output logic [2:0]  event_button,
  output logic [2:0]  event_action,
  output logic [3:0]  event_key,
  output logic        event_last
);

  localparam int SL = bdhrk_pkg::SLOTS;

  // Configuration registers.
  logic        press_low;
  logic [5:0]  button_enable;
  logic [15:0] debounce_ms;
  logic [15:0] hold_delay_ms;
  logic [15:0] repeat_ms;

  // Per-slot state.
  logic [SL-1:0]        stable_level;
  logic [TIME_BITS-1:0] change_time    [SL];
  logic [TIME_BITS-1:0] next_fire_time [SL];
  logic [SL-1:0]        holding;
  logic [SL-1:0]        long_done;

  // The captured poll.
  logic [TIME_BITS-1:0] now;
  logic [5:0]           lv;
  logic                 menu;
  logic [1:0]           mode;

  // Sequencer.
  bdhrk_pkg::state_t state, state_next;
  logic [2:0] slot, slot_next;
  logic       have, have_next;
  logic [2:0] act, act_next;
  logic [3:0] key, key_next;

  // Shared time adder.
  bdhrk_pkg::alu_op_t   alu_op;
  logic [TIME_BITS-1:0] alu_b;
  logic [TIME_BITS-1:0] alu_res;
  logic                 alu_above;
  logic                 alu_ahead;
  logic [TIME_BITS-1:0] debounce_ext;

  // Slot update strobes.
  logic wr_change, set_hold, clr_hold, clr_long, set_long, wr_fire;
  logic slot_done, push, drain_start, draining;

  logic            cur;
  logic            pressed_level;
  logic            deferred;
  bdhrk_pkg::map_t mp;
  bdhrk_pkg::event_t push_event;

  assign cur           = lv[slot];
  assign pressed_level = ~press_low;
  assign deferred      = (slot == bdhrk_pkg::SLOT_LEFT) || (slot == bdhrk_pkg::SLOT_RIGHT) ||
                         (slot == bdhrk_pkg::SLOT_CENTER);
  assign mp            = bdhrk_pkg::map_short(slot, menu, mode);
  assign debounce_ext  = TIME_BITS'(debounce_ms);
  assign poll_stall    = (state != bdhrk_pkg::ST_IDLE);

  bdhrk_time_alu #(
    .TIME_BITS (TIME_BITS)
  ) u_alu (
    .op     (alu_op),
    .a      (now),
    .b      (alu_b),
    .limit  (debounce_ext),
    .result (alu_res),
    .above  (alu_above),
    .ahead  (alu_ahead)
  );

  // Configuration writes. Writes beyond the register list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      press_low     <= 1'b0;
      button_enable <= '0;
      debounce_ms   <= 16'd50;
      hold_delay_ms <= 16'd500;
      repeat_ms     <= 16'd100;
    end else if (cfg_write) begin
      unique case (cfg_index)
        bdhrk_pkg::REG_PRESS_LOW:  press_low     <= cfg_data[0];
        bdhrk_pkg::REG_ENABLE:     button_enable <= cfg_data[5:0];
        bdhrk_pkg::REG_DEBOUNCE:   debounce_ms   <= cfg_data;
        bdhrk_pkg::REG_HOLD_DELAY: hold_delay_ms <= cfg_data;
        bdhrk_pkg::REG_REPEAT:     repeat_ms     <= cfg_data;
        default: ;
      endcase
    end
  end

  // The poll is held for the whole scan.
  always_ff @(posedge clk) begin
    if (state == bdhrk_pkg::ST_IDLE && poll_valid) begin
      now  <= TIME_BITS'(now_ms);
      lv   <= levels;
      menu <= menu_open;
      mode <= ui_mode;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bdhrk_pkg::ST_IDLE;
      slot  <= '0;
      have  <= 1'b0;
    end else begin
      state <= state_next;
      slot  <= slot_next;
      have  <= have_next;
    end
  end

  always_ff @(posedge clk) begin
    act <= act_next;
    key <= key_next;
  end

  // Slot state. Only the slot under the sequencer changes in a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      stable_level <= '0;
      holding      <= '0;
      long_done    <= '0;
      for (int i = 0; i < SL; i++) begin
        change_time[i]    <= '0;
        next_fire_time[i] <= '0;
      end
    end else begin
      if (wr_change) begin
        stable_level[slot] <= cur;
        change_time[slot]  <= now;
      end
      if (set_hold) begin
        holding[slot] <= 1'b1;
      end else if (clr_hold) begin
        holding[slot] <= 1'b0;
      end
      if (clr_long) begin
        long_done[slot] <= 1'b0;
      end else if (set_long) begin
        long_done[slot] <= 1'b1;
      end
      if (wr_fire) begin
        next_fire_time[slot] <= alu_res;
      end
    end
  end

  // Sequencer. Each enabled slot runs a debounce step, an optional deadline
  // step after an accepted press, a fire test and an optional repeat step.
  // The deadline is written before the fire test, so a press and a repeat in
  // the same poll see the new deadline, and the later event wins.
  always_comb begin
    state_next  = state;
    slot_next   = slot;
    have_next   = have;
    act_next    = act;
    key_next    = key;
    alu_op      = bdhrk_pkg::ALU_SUB;
    alu_b       = change_time[slot];
    wr_change   = 1'b0;
    set_hold    = 1'b0;
    clr_hold    = 1'b0;
    clr_long    = 1'b0;
    set_long    = 1'b0;
    wr_fire     = 1'b0;
    slot_done   = 1'b0;
    drain_start = 1'b0;
    unique case (state)
      bdhrk_pkg::ST_IDLE: begin
        if (poll_valid) begin
          slot_next  = '0;
          state_next = bdhrk_pkg::ST_DEB;
        end
      end
      bdhrk_pkg::ST_DEB: begin
        have_next = 1'b0;
        if (!button_enable[slot]) begin
          slot_done = 1'b1;
        end else if (cur != stable_level[slot] && alu_above) begin
          wr_change = 1'b1;
          if (cur == pressed_level) begin
            set_hold   = 1'b1;
            clr_long   = 1'b1;
            have_next  = !deferred && mp.hit;
            act_next   = mp.action;
            key_next   = mp.key;
            state_next = bdhrk_pkg::ST_HOLD;
          end else begin
            clr_hold = 1'b1;
            if (deferred && !long_done[slot]) begin
              have_next = mp.hit;
              act_next  = mp.action;
              key_next  = mp.key;
            end else begin
              have_next = 1'b1;
              act_next  = bdhrk_pkg::ACT_RELEASE;
              key_next  = bdhrk_pkg::KEY_NONE;
            end
            state_next = bdhrk_pkg::ST_FIRE;
          end
        end else begin
          state_next = bdhrk_pkg::ST_FIRE;
        end
      end
      bdhrk_pkg::ST_HOLD: begin
        alu_op     = bdhrk_pkg::ALU_ADD;
        alu_b      = TIME_BITS'(hold_delay_ms);
        wr_fire    = 1'b1;
        state_next = bdhrk_pkg::ST_FIRE;
      end
      bdhrk_pkg::ST_FIRE: begin
        alu_b = next_fire_time[slot];
        if (holding[slot] && cur == pressed_level && alu_ahead) begin
          if (deferred) begin
            if (!long_done[slot]) begin
              set_long = 1'b1;
              // A long press on center opens the menu, or in the menu sends home (nav mode) or escape.
              if (slot == bdhrk_pkg::SLOT_CENTER) begin
                have_next = 1'b1;
                if (!menu) begin
                  act_next = bdhrk_pkg::ACT_OPEN_MENU;
                  key_next = bdhrk_pkg::KEY_NONE;
                end else begin
                  act_next = bdhrk_pkg::ACT_PRESS;
                  key_next = (mode == bdhrk_pkg::MODE_NAV) ? bdhrk_pkg::KEY_HOME
                                                           : bdhrk_pkg::KEY_ESC;
                end
              end
            end
            slot_done = 1'b1;
          end else begin
            if (mp.hit) begin
              have_next = 1'b1;
              act_next  = mp.action;
              key_next  = mp.key;
            end
            state_next = bdhrk_pkg::ST_REP;
          end
        end else begin
          slot_done = 1'b1;
        end
      end
      bdhrk_pkg::ST_REP: begin
        alu_op    = bdhrk_pkg::ALU_ADD;
        alu_b     = TIME_BITS'(repeat_ms);
        wr_fire   = 1'b1;
        slot_done = 1'b1;
      end
      bdhrk_pkg::ST_DRAIN: begin
        if (!draining) begin
          state_next = bdhrk_pkg::ST_IDLE;
        end
      end
      default: state_next = bdhrk_pkg::ST_IDLE;
    endcase
    if (slot_done) begin
      if (slot == 3'(SL - 1)) begin
        drain_start = 1'b1;
        state_next  = bdhrk_pkg::ST_DRAIN;
      end else begin
        slot_next  = slot + 3'd1;
        state_next = bdhrk_pkg::ST_DEB;
      end
    end
  end

  assign push              = slot_done && have_next;
  assign push_event.button = slot;
  assign push_event.action = act_next;
  assign push_event.key    = key_next;

  bdhrk_event_buf u_buf (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .push_event   (push_event),
    .drain_start  (drain_start),
    .draining     (draining),
    .event_valid  (event_valid),
    .event_stall  (event_stall),
    .event_button (event_button),
    .event_action (event_action),
    .event_key    (event_key),
    .event_last   (event_last)
  );

endmodule

@@ sv/bdhrk_time_alu.sv @@
// ----------------------------------------------------------------------------
// bdhrk_time_alu: shared wrap-around time adder
// One add or subtract per cycle, with a magnitude compare against a limit
// and a half-range sign test on the result.
// ----------------------------------------------------------------------------
module bdhrk_time_alu #(
  parameter int TIME_BITS = 32
) (
  input  bdhrk_pkg::alu_op_t    op,
  input  logic [TIME_BITS-1:0]  a,
  input  logic [TIME_BITS-1:0]  b,
  input  logic [TIME_BITS-1:0]  limit,
  output logic [TIME_BITS-1:0]  result,
  output logic                  above,
  output logic                  ahead
);

  assign result = (op == bdhrk_pkg::ALU_ADD) ? a + b : a - b;
  assign above  = result > limit;
  // A clear top bit means the target time has been reached or passed.
  assign ahead  = ~result[TIME_BITS-1];

endmodule

@@ sv/bdhrk_event_buf.sv @@
// ----------------------------------------------------------------------------
// bdhrk_event_buf: event collection buffer and output register
// Holds the events of one poll, then drains them in order onto the output
// channel and marks the final beat as last.
// ----------------------------------------------------------------------------
module bdhrk_event_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  bdhrk_pkg::event_t   push_event,
  input  logic                drain_start,
  output logic                draining,
  output logic                event_valid,
  input  logic                event_stall,
  output logic [2:0]          event_button,
  output logic [2:0]          event_action,
  output logic [3:0]          event_key,
  output logic                event_last
);

  bdhrk_pkg::event_t entries [bdhrk_pkg::SLOTS];
  logic [2:0] count;
  logic [2:0] rd_ptr;
  logic       load;

  assign load = draining && (rd_ptr != count) && (!event_valid || !event_stall);

  always_ff @(posedge clk) begin
    if (push) begin
      entries[count] <= push_event;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      rd_ptr   <= '0;
      draining <= 1'b0;
    end else begin
      if (push) begin
        count <= count + 3'd1;
      end
      if (drain_start) begin
        draining <= 1'b1;
      end else if (draining && rd_ptr == count) begin
        draining <= 1'b0;
        count    <= '0;
        rd_ptr   <= '0;
      end else if (load) begin
        rd_ptr <= rd_ptr + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      event_valid <= 1'b0;
    end else if (load) begin
      event_valid <= 1'b1;
    end else if (!event_stall) begin
      event_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      event_button <= entries[rd_ptr].button;
      event_action <= entries[rd_ptr].action;
      event_key    <= entries[rd_ptr].key;
      event_last   <= (rd_ptr == count - 3'd1);
    end
  end

endmodule
